// File: rtl/cubic_spline_coefficients_top_assert.svh
// Assertion macros for the cubic spline coefficient block.
// Used by cubic_spline_coefficients_top; expects clk_i and rst_ni in scope.
`ifndef CUBIC_SPLINE_COEFFICIENTS_TOP_ASSERT_SVH
`define CUBIC_SPLINE_COEFFICIENTS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CSC_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  (prop)) else $error("spline assertion failed");
`define CSC_ASSERT_NR(lbl, prop) lbl: assert property (@(posedge clk_i) (prop)) \
  else $error("spline reset assertion failed");
`else
`define CSC_ASSERT(lbl, prop)
`define CSC_ASSERT_NR(lbl, prop)
`endif
`endif

// File: rtl/csc_pkg.sv
// Shared types, widths and helpers for the cubic spline coefficient block.
// No dependencies.
package csc_pkg;

  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned GFRAC  = 24;          // gamma fraction bits
  localparam int unsigned GW     = 25;          // gamma width (value < 1.0)
  localparam int unsigned VW     = 40;          // sweep / slope width
  localparam int unsigned WIDE_W = 44;          // coefficient width before saturation
  localparam int unsigned DEN_W  = GFRAC + 3;   // reciprocal denominator
  localparam int unsigned NUM_W  = 2 * GFRAC + 1;
  localparam int unsigned LO_W   = VW / 2;      // multiplier split point

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef logic [2:0][31:0] pt_word_t;

  typedef struct packed {
    logic [GW-1:0]        g;
    logic [2:0][VW-1:0]   d;
  } sw_word_t;

  function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [31:0] r;
    if (v > WIDE_W'(signed'(33'sh0_7FFF_FFFF))) begin
      r = 32'h7FFF_FFFF;
    end else if (v < WIDE_W'(signed'(-33'sh0_8000_0000))) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/csc_if.sv
// Valid/ready channel interfaces for control points in and coefficients out.
// No dependencies.
interface csc_pt_if;
  logic        valid;
  logic        ready;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] z;
  logic        last;

  modport source (output valid, x, y, z, last, input ready);
  modport sink   (input valid, x, y, z, last, output ready);
endinterface

interface csc_cf_if;
  logic        valid;
  logic        ready;
  logic [1:0]  axis;
  logic [3:0]  segment;
  logic [31:0] coef_a;
  logic [31:0] coef_b;
  logic [31:0] coef_c;
  logic [31:0] coef_d;
  logic        end_of_run;
  logic        error;

  modport source (output valid, axis, segment, coef_a, coef_b, coef_c, coef_d,
                  end_of_run, error, input ready);
  modport sink   (input valid, axis, segment, coef_a, coef_b, coef_c, coef_d,
                  end_of_run, error, output ready);
endinterface

// File: rtl/cubic_spline_coefficients_top.sv
// Natural cubic spline coefficients over x, y, z. Points load one word per cycle, while
// idle, into the point memory; the word with last set closes the set and starts the solve.
// Per point the forward sweep runs the bit-serial reciprocal divider (not for the first
// point, which needs no divide), the split 40x25 multiplier once per axis, and memory and
// control steps; the back substitution runs the multiplier once per axis. A lone point
// gives an error word in place of a solve. Words then go out, one per axis and segment,
// while the sink is ready.
// No point is taken while a set is solved or emitted.
// Depends on csc_pkg, csc_if and cubic_spline_coefficients_top_assert.svh.
`include "cubic_spline_coefficients_top_assert.svh"

module cubic_spline_coefficients_top #(
  parameter int unsigned MAX_POINTS = csc_pkg::MAX_POINTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csc_pt_if.sink     pts_i,
  csc_cf_if.source   cfs_o
);
  import csc_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_POINTS);
  localparam int unsigned CNW = $clog2(MAX_POINTS + 1);
  localparam int unsigned DCW = $clog2(NUM_W);
  localparam int unsigned SN  = 22;

  typedef enum logic [SN-1:0] {
    S_IDLE   = SN'(1) << 0,
    S_F_PRE  = SN'(1) << 1,
    S_F_GAM  = SN'(1) << 2,
    S_F_DIV  = SN'(1) << 3,
    S_F_LOAD = SN'(1) << 4,
    S_F_AX   = SN'(1) << 5,
    S_F_AXD  = SN'(1) << 6,
    S_F_WR   = SN'(1) << 7,
    S_B_RD   = SN'(1) << 8,
    S_B_AX   = SN'(1) << 9,
    S_B_AXD  = SN'(1) << 10,
    S_B_WR   = SN'(1) << 11,
    S_M_LO   = SN'(1) << 12,
    S_M_HI   = SN'(1) << 13,
    S_M_FIN  = SN'(1) << 14,
    S_E_RD0  = SN'(1) << 15,
    S_E_CAP0 = SN'(1) << 16,
    S_E_RD   = SN'(1) << 17,
    S_E_CAP  = SN'(1) << 18,
    S_E_CALC = SN'(1) << 19,
    S_E_WAIT = SN'(1) << 20,
    S_ERR    = SN'(1) << 21
  } state_e;

  state_e state_q, state_d, ret_q;

  // memories
  pt_word_t pmem [MAX_POINTS];
  sw_word_t wmem [MAX_POINTS];
  pt_word_t pm_rd_q;
  sw_word_t wm_rd_q;
  logic     pm_re, wm_re, pm_we, wm_we;
  logic [IW-1:0] pm_raddr, wm_raddr, wm_waddr;
  sw_word_t wm_wdata;

  // control
  logic [CNW-1:0] cnt_q, cnt_new;
  logic           ovf_q, err_q, cnt_full, acc;
  logic [IW-1:0]  n_q, i_q, i_inc;
  logic [1:0]     ax_q;

  // solve datapath
  logic [GW-1:0]            gprev_q, gcur_q, mg_q;
  pt_word_t                 vm1_q, vcur_q, vnext_q;
  logic [2:0][VW-1:0]       dl_q, scur_q, snext_q;
  logic signed [VW-1:0]     mop_q, mres_q;
  logic [LO_W+GW-1:0]       plo_q, phi_q;
  logic [DEN_W-1:0]         den_q, rem_q, den_d;
  logic [NUM_W-1:0]         num_q;
  logic [GW-1:0]            quo_q;
  logic [DCW-1:0]           dcnt_q;

  // output register
  logic        out_valid_q, eor_q, oerr_q;
  logic [1:0]  oax_q;
  logic [3:0]  oseg_q;
  logic [31:0] oa_q, ob_q, oc_q, od_q;

  assign acc      = pts_i.valid && pts_i.ready;
  assign cnt_full = (cnt_q == CNW'(MAX_POINTS));
  assign cnt_new  = cnt_full ? cnt_q : cnt_q + 1'b1;
  assign i_inc    = IW'({1'b0, i_q} + 1'b1);
  assign pts_i.ready = (state_q == S_IDLE);

  // forward right side: 3*(vhi - vlo) - dl[i-1]
  pt_word_t                vhi_w, vlo_w;
  logic signed [32:0]      fdiff;
  logic signed [VW+1:0]    fd_w, dlp_w, rhs;
  always_comb begin
    vhi_w = (i_q == n_q) ? vcur_q : vnext_q;
    vlo_w = (i_q == '0) ? vcur_q : vm1_q;
    fdiff = $signed({vhi_w[ax_q][31], vhi_w[ax_q]}) - $signed({vlo_w[ax_q][31], vlo_w[ax_q]});
    fd_w  = (VW+2)'(fdiff);
    dlp_w = (i_q == '0) ? '0 : (VW+2)'($signed(dl_q[ax_q]));
    rhs   = fd_w + (fd_w <<< 1) - dlp_w;
  end

  // gamma multiply: magnitude split in two halves, rounded half away from zero
  logic [VW-1:0]          mag;
  logic [VW+GW:0]         msum;
  logic [VW-1:0]          mq;
  always_comb begin
    mag  = mop_q[VW-1] ? VW'(-mop_q) : VW'(mop_q);
    msum = ((VW+GW+1)'(phi_q) << LO_W) + (VW+GW+1)'(plo_q)
         + ((VW+GW+1)'(1) << (GFRAC - 1));
    mq   = VW'(msum >> GFRAC);
  end

  // reciprocal divider step
  logic [DEN_W:0]   dv_t;
  logic             dv_ge;
  logic [DEN_W-1:0] rem_nx;
  always_comb begin
    dv_t   = {rem_q, num_q[NUM_W-1]};
    dv_ge  = dv_t >= {1'b0, den_q};
    rem_nx = dv_ge ? DEN_W'(dv_t - {1'b0, den_q}) : dv_t[DEN_W-1:0];
    den_d  = ((i_q == n_q) ? (DEN_W'(2) << GFRAC) : (DEN_W'(4) << GFRAC)) - DEN_W'(gprev_q);
  end

  // coefficient words
  logic signed [32:0]       edv;
  logic signed [WIDE_W-1:0] dvw, s0w, s1w, cw, dw;
  logic                     eor_w;
  always_comb begin
    edv = $signed({vnext_q[ax_q][31], vnext_q[ax_q]})
        - $signed({vcur_q[ax_q][31], vcur_q[ax_q]});
    dvw = WIDE_W'(edv);
    s0w = WIDE_W'($signed(scur_q[ax_q]));
    s1w = WIDE_W'($signed(snext_q[ax_q]));
    cw  = dvw + (dvw <<< 1) - (s0w <<< 1) - s1w;
    dw  = s0w + s1w - (dvw <<< 1);
    eor_w = (i_inc == n_q) && (ax_q == AX_Z);
  end

  // memory access control
  always_comb begin
    pm_we    = acc && !cnt_full;
    pm_re    = 1'b0;
    pm_raddr = i_inc;
    wm_re    = 1'b0;
    wm_raddr = i_inc;
    wm_we    = 1'b0;
    wm_waddr = i_q;
    wm_wdata = '{g: gcur_q, d: dl_q};
    case (state_q)
      S_F_PRE: begin
        pm_re    = 1'b1;
        pm_raddr = '0;
      end
      S_F_GAM: pm_re = (i_q != n_q);
      S_F_WR:  wm_we = 1'b1;
      S_B_RD: begin
        wm_re    = 1'b1;
        wm_raddr = IW'(i_q - 1'b1);
      end
      S_B_WR: begin
        wm_we    = 1'b1;
        wm_waddr = IW'(i_q - 1'b1);
        wm_wdata = '{g: wm_rd_q.g, d: dl_q};
      end
      S_E_RD0: begin
        pm_re    = 1'b1;
        pm_raddr = '0;
        wm_re    = 1'b1;
        wm_raddr = '0;
      end
      S_E_CAP0, S_E_RD: begin
        pm_re = 1'b1;
        wm_re = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) pmem[cnt_q[IW-1:0]] <= {pts_i.z, pts_i.y, pts_i.x};
    if (pm_re) pm_rd_q <= pmem[pm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wm_we) wmem[wm_waddr] <= wm_wdata;
    if (wm_re) wm_rd_q <= wmem[wm_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && pts_i.last) state_d = (cnt_new < CNW'(2)) ? S_ERR : S_F_PRE;
      end
      S_F_PRE:  state_d = S_F_GAM;
      S_F_GAM:  state_d = (i_q == '0) ? S_F_LOAD : S_F_DIV;
      S_F_DIV:  if (dcnt_q == '0) state_d = S_F_LOAD;
      S_F_LOAD: state_d = S_F_AX;
      S_F_AX:   state_d = S_M_LO;
      S_F_AXD:  state_d = (ax_q == AX_Z) ? S_F_WR : S_F_AX;
      S_F_WR:   state_d = (i_q == n_q) ? S_B_RD : S_F_GAM;
      S_B_RD:   state_d = S_B_AX;
      S_B_AX:   state_d = S_M_LO;
      S_B_AXD:  state_d = (ax_q == AX_Z) ? S_B_WR : S_B_AX;
      S_B_WR:   state_d = (i_q == IW'(1)) ? S_E_RD0 : S_B_RD;
      S_M_LO:   state_d = S_M_HI;
      S_M_HI:   state_d = S_M_FIN;
      S_M_FIN:  state_d = ret_q;
      S_E_RD0:  state_d = S_E_CAP0;
      S_E_CAP0: state_d = S_E_CAP;
      S_E_RD:   state_d = S_E_CAP;
      S_E_CAP:  state_d = S_E_CALC;
      S_E_CALC: state_d = S_E_WAIT;
      S_E_WAIT: begin
        if (cfs_o.ready) begin
          if (eor_q)              state_d = S_IDLE;
          else if (ax_q == AX_Z)  state_d = S_E_RD;
          else                    state_d = S_E_CALC;
        end
      end
      S_ERR:    state_d = S_E_WAIT;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (pts_i.last) begin
              cnt_q <= '0;
              ovf_q <= 1'b0;
            end else begin
              cnt_q <= cnt_new;
              ovf_q <= ovf_q | cnt_full;
            end
          end
        end
        S_F_AX, S_B_AX: ret_q <= (state_q == S_F_AX) ? S_F_AXD : S_B_AXD;
        S_E_CALC, S_ERR: out_valid_q <= 1'b1;
        S_E_WAIT: if (cfs_o.ready) out_valid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (acc && pts_i.last) begin
          n_q   <= IW'(cnt_new - 1'b1);
          err_q <= ovf_q | cnt_full;
          i_q   <= '0;
        end
      end
      S_F_GAM: begin
        if (i_q == '0) begin
          vcur_q <= pm_rd_q;
          gcur_q <= GW'(1) << (GFRAC - 1);
        end else begin
          den_q  <= den_d;
          num_q  <= (NUM_W'(1) << (2 * GFRAC)) + NUM_W'(den_d >> 1);
          rem_q  <= '0;
          quo_q  <= '0;
          dcnt_q <= DCW'(NUM_W - 1);
        end
      end
      S_F_DIV: begin
        rem_q  <= rem_nx;
        num_q  <= num_q << 1;
        quo_q  <= {quo_q[GW-2:0], dv_ge};
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == '0) gcur_q <= {quo_q[GW-2:0], dv_ge};
      end
      S_F_LOAD: begin
        vnext_q <= pm_rd_q;
        ax_q    <= AX_X;
      end
      S_F_AX: begin
        mop_q <= VW'(rhs);
        mg_q  <= gcur_q;
      end
      S_F_AXD: begin
        dl_q[ax_q] <= mres_q;
        ax_q       <= ax_q + 1'b1;
      end
      S_F_WR: begin
        gprev_q <= gcur_q;
        vm1_q   <= vcur_q;
        vcur_q  <= vnext_q;
        if (i_q != n_q) i_q <= i_inc;
      end
      S_B_RD: ax_q <= AX_X;
      S_B_AX: begin
        mop_q <= $signed(dl_q[ax_q]);
        mg_q  <= wm_rd_q.g;
      end
      S_B_AXD: begin
        dl_q[ax_q] <= VW'($signed(wm_rd_q.d[ax_q]) - mres_q);
        ax_q       <= ax_q + 1'b1;
      end
      S_B_WR: i_q <= IW'(i_q - 1'b1);
      S_M_LO: plo_q <= (LO_W+GW)'(mag[LO_W-1:0]) * (LO_W+GW)'(mg_q);
      S_M_HI: phi_q <= (LO_W+GW)'(mag[VW-1:LO_W]) * (LO_W+GW)'(mg_q);
      S_M_FIN: mres_q <= mop_q[VW-1] ? VW'(-mq) : mq;
      S_E_CAP0: begin
        vcur_q <= pm_rd_q;
        scur_q <= wm_rd_q.d;
      end
      S_E_CAP: begin
        vnext_q <= pm_rd_q;
        snext_q <= wm_rd_q.d;
        ax_q    <= AX_X;
      end
      S_E_CALC: begin
        oax_q  <= ax_q;
        oseg_q <= 4'(i_q);
        oa_q   <= vcur_q[ax_q];
        ob_q   <= sat32(s0w);
        oc_q   <= sat32(cw);
        od_q   <= sat32(dw);
        eor_q  <= eor_w;
        oerr_q <= err_q;
      end
      S_E_WAIT: begin
        if (cfs_o.ready && !eor_q) begin
          if (ax_q == AX_Z) begin
            vcur_q <= vnext_q;
            scur_q <= snext_q;
            i_q    <= i_inc;
          end else begin
            ax_q <= ax_q + 1'b1;
          end
        end
      end
      S_ERR: begin
        oax_q  <= AX_X;
        oseg_q <= '0;
        oa_q   <= '0;
        ob_q   <= '0;
        oc_q   <= '0;
        od_q   <= '0;
        eor_q  <= 1'b1;
        oerr_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign cfs_o.valid      = out_valid_q;
  assign cfs_o.axis       = oax_q;
  assign cfs_o.segment    = oseg_q;
  assign cfs_o.coef_a     = oa_q;
  assign cfs_o.coef_b     = ob_q;
  assign cfs_o.coef_c     = oc_q;
  assign cfs_o.coef_d     = od_q;
  assign cfs_o.end_of_run = eor_q;
  assign cfs_o.error      = oerr_q;

  `CSC_ASSERT(a_rdy_no_out, pts_i.ready |-> !out_valid_q)
  `CSC_ASSERT(a_cnt_cap, cnt_q <= CNW'(MAX_POINTS))
  `CSC_ASSERT(a_eor_idle, (cfs_o.valid && cfs_o.ready && cfs_o.end_of_run) |=> (state_q == S_IDLE))
  `CSC_ASSERT(a_den_range, (state_q == S_F_DIV) |-> (den_q[DEN_W-1:GFRAC] != '0))
  `CSC_ASSERT_NR(a_rst_idle, !rst_ni |-> (state_q == S_IDLE))

endmodule
